@@ src/mcr_pkg.sv @@
// Shared types and codes for the midpoint circle rasterizer.
package mcr_pkg;

    // Opcodes carried in the input tuser
    localparam logic OP_START = 1'b0;
    localparam logic OP_STEP  = 1'b1;

    // Index of the final result of a step, by kind of step
    localparam logic [2:0] LAST_EMPTY   = 3'd0;
    localparam logic [2:0] LAST_FILL    = 3'd3;
    localparam logic [2:0] LAST_OUTLINE = 3'd7;

    localparam int CoordW  = 15;
    localparam int RadiusW = 14;
    localparam int DecW    = 17;
    localparam int OutW    = 16;

    // Snapshot of one step: everything the emitter needs to produce its results
    typedef struct packed {
        logic signed [CoordW-1:0] cx;
        logic signed [CoordW-1:0] cy;
        logic signed [CoordW-1:0] ox;
        logic signed [CoordW-1:0] oy;
        logic                     filled;
        logic                     done;
        logic                     empty;
    } job_t;

    // Emitter status seen by the top level
    typedef struct packed {
        logic job_busy;
        logic out_load;
    } emit_stat_t;

endpackage

@@ src/mcr_state.sv @@
// Circle state registers and the midpoint decision update.
module mcr_state
    import mcr_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      item_acc,
    input  logic                      opcode,
    input  logic signed [CoordW-1:0]  center_x,
    input  logic signed [CoordW-1:0]  center_y,
    input  logic        [RadiusW-1:0] radius,
    input  logic                      fill_mode,
    output job_t                      job
);

    logic signed [CoordW-1:0]  cx_reg, cy_reg, ox_reg, oy_reg;
    logic        [RadiusW-1:0] rad_reg;
    logic signed [DecW-1:0]    dec_reg;
    logic                      filled_reg, active_reg;

    logic signed [18:0] d_w, ox_w, oy_w, rad_w, d_n, ox_n, oy_n;
    logic signed [CoordW-1:0] ox_next, oy_next;
    logic signed [DecW-1:0]   dec_next;
    logic                     done;

    // Three-way decision rule on widened values
    always_comb
    begin
        d_w   = 19'(dec_reg);
        ox_w  = 19'(ox_reg);
        oy_w  = 19'(oy_reg);
        rad_w = $signed({5'b0, rad_reg});
        if (d_w >= (ox_w <<< 1))
        begin
            d_n  = d_w - (ox_w <<< 1) - 19'sd1;
            ox_n = ox_w + 19'sd1;
            oy_n = oy_w;
        end
        else if (d_w < ((rad_w - oy_w) <<< 1))
        begin
            d_n  = d_w + (oy_w <<< 1) - 19'sd1;
            ox_n = ox_w;
            oy_n = oy_w - 19'sd1;
        end
        else
        begin
            d_n  = d_w + ((oy_w - ox_w - 19'sd1) <<< 1);
            ox_n = ox_w + 19'sd1;
            oy_n = oy_w - 19'sd1;
        end
        ox_next  = ox_n[CoordW-1:0];
        oy_next  = oy_n[CoordW-1:0];
        dec_next = d_n[DecW-1:0];
        done     = oy_next < ox_next;
    end

    // Snapshot handed to the emitter on a step transfer
    always_comb
    begin
        job.cx     = cx_reg;
        job.cy     = cy_reg;
        job.ox     = ox_reg;
        job.oy     = oy_reg;
        job.filled = filled_reg;
        job.done   = done;
        job.empty  = !active_reg;
    end

    // State update
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cx_reg     <= '0;
            cy_reg     <= '0;
            rad_reg    <= '0;
            ox_reg     <= '0;
            oy_reg     <= '0;
            dec_reg    <= '0;
            filled_reg <= 1'b0;
            active_reg <= 1'b0;
        end
        else if (item_acc)
        begin
            if (opcode == OP_START)
            begin
                cx_reg     <= center_x;
                cy_reg     <= center_y;
                rad_reg    <= radius;
                ox_reg     <= '0;
                oy_reg     <= $signed({1'b0, radius});
                dec_reg    <= $signed(DecW'(radius) - DecW'(1));
                filled_reg <= fill_mode;
                active_reg <= 1'b1;
            end
            else if (active_reg)
            begin
                ox_reg     <= ox_next;
                oy_reg     <= oy_next;
                dec_reg    <= dec_next;
                active_reg <= !done;
            end
        end
    end

endmodule

@@ src/mcr_emit.sv @@
// Step job register, per-result coordinate selection and output register.
module mcr_emit
    import mcr_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   job_load,
    input  job_t                   job,
    output logic                   job_free,
    output emit_stat_t             stat,
    output logic                   m_valid,
    input  logic                   m_ready,
    output logic signed [OutW-1:0] x_start,
    output logic signed [OutW-1:0] x_end,
    output logic signed [OutW-1:0] row_y,
    output logic                   last_of_run,
    output logic                   circle_done,
    output logic                   empty_res
);

    job_t       job_reg;
    logic       job_valid_reg;
    logic [2:0] idx_reg;

    logic                   m_valid_reg;
    logic signed [OutW-1:0] xs_reg, xe_reg, y_reg;
    logic                   last_reg, done_reg, empty_reg;

    logic [2:0]             last_idx;
    logic                   is_last, out_load;
    logic signed [OutW-1:0] xc, yc, a, b;
    logic signed [OutW-1:0] xpa, xma, xpb, xmb, ypa, yma, ypb, ymb;
    logic signed [OutW-1:0] xs_c, xe_c, y_c;

    // Octant sums, wrapped to the output width
    always_comb
    begin
        xc  = OutW'(job_reg.cx);
        yc  = OutW'(job_reg.cy);
        a   = OutW'(job_reg.ox);
        b   = OutW'(job_reg.oy);
        xpa = xc + a;
        xma = xc - a;
        xpb = xc + b;
        xmb = xc - b;
        ypa = yc + a;
        yma = yc - a;
        ypb = yc + b;
        ymb = yc - b;
    end

    // Pick the point or span for the current index
    always_comb
    begin
        xs_c = '0;
        xe_c = '0;
        y_c  = '0;
        if (job_reg.empty)
        begin
            xs_c = '0;
            xe_c = '0;
            y_c  = '0;
        end
        else if (job_reg.filled)
        begin
            case (idx_reg[1:0])
                2'd0:    begin xs_c = xmb; xe_c = xpb; y_c = ypa; end
                2'd1:    begin xs_c = xma; xe_c = xpa; y_c = ypb; end
                2'd2:    begin xs_c = xma; xe_c = xpa; y_c = ymb; end
                default: begin xs_c = xmb; xe_c = xpb; y_c = yma; end
            endcase
        end
        else
        begin
            case (idx_reg)
                3'd0:    begin xs_c = xpa; y_c = ypb; end
                3'd1:    begin xs_c = xpb; y_c = ypa; end
                3'd2:    begin xs_c = xma; y_c = ypb; end
                3'd3:    begin xs_c = xmb; y_c = ypa; end
                3'd4:    begin xs_c = xpa; y_c = ymb; end
                3'd5:    begin xs_c = xpb; y_c = yma; end
                3'd6:    begin xs_c = xma; y_c = ymb; end
                default: begin xs_c = xmb; y_c = yma; end
            endcase
            xe_c = xs_c;
        end
    end

    // Transfer bookkeeping
    always_comb
    begin
        if (job_reg.empty)
            last_idx = LAST_EMPTY;
        else if (job_reg.filled)
            last_idx = LAST_FILL;
        else
            last_idx = LAST_OUTLINE;
        is_last  = idx_reg == last_idx;
        out_load = job_valid_reg && (!m_valid_reg || m_ready);
        job_free = !job_valid_reg || (out_load && is_last);
    end

    assign stat.job_busy = job_valid_reg;
    assign stat.out_load = out_load;

    // Job register and result index
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            job_valid_reg <= 1'b0;
            idx_reg       <= '0;
        end
        else if (job_load)
        begin
            job_valid_reg <= 1'b1;
            idx_reg       <= '0;
        end
        else if (out_load)
        begin
            if (is_last)
                job_valid_reg <= 1'b0;
            idx_reg <= idx_reg + 3'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (job_load)
            job_reg <= job;
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_valid_reg <= 1'b0;
        else if (out_load)
            m_valid_reg <= 1'b1;
        else if (m_ready)
            m_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            xs_reg    <= xs_c;
            xe_reg    <= xe_c;
            y_reg     <= y_c;
            last_reg  <= is_last;
            done_reg  <= is_last && job_reg.done;
            empty_reg <= job_reg.empty;
        end
    end

    assign m_valid     = m_valid_reg;
    assign x_start     = xs_reg;
    assign x_end       = xe_reg;
    assign row_y       = y_reg;
    assign last_of_run = last_reg;
    assign circle_done = done_reg || empty_reg;
    assign empty_res   = empty_reg;

endmodule

@@ src/midpoint_circle_rasterizer.sv @@
// Top level of the midpoint circle rasterizer.
//
//  channel   dir  tdata                                   tuser / tlast
//  s_axis    in   center_x, center_y, radius, fill_mode   tuser: opcode
//  m_axis    out  x_start, x_end, row_y                   tuser: circle_done, empty_res;
//                                                         tlast: last_of_run
//
// A start transfer gives no result. A step gives eight results in outline mode,
// four in fill mode, one when no circle is active, at one result per cycle
// from the output register while the output is not stalled.
// Reset clears the circle state (no circle active) and the job and output valids.
// The next input is taken while the last result of the current step loads;
// output stalls hold the job and in turn the input.
module midpoint_circle_rasterizer
    import mcr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [47:0] s_axis_tdata,  // center_x[14:0], center_y[29:15], radius[43:30],
                                       // fill_mode[44], zero fill[47:45]
    input  logic        s_axis_tuser,  // opcode
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata,  // x_start[15:0], x_end[31:16], row_y[47:32]
    output logic [1:0]  m_axis_tuser,  // circle_done[0], empty_res[1]
    output logic        m_axis_tlast   // last_of_run
);

    logic       item_acc, job_load, job_free;
    job_t       job;
    emit_stat_t stat;
    logic signed [OutW-1:0] x_start, x_end, row_y;
    logic       last_of_run, circle_done, empty_res;

    assign s_axis_tready = job_free;
    assign item_acc      = s_axis_tvalid && s_axis_tready;
    assign job_load      = item_acc && (s_axis_tuser == OP_STEP);

    mcr_state u_state
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .item_acc  (item_acc),
        .opcode    (s_axis_tuser),
        .center_x  ($signed(s_axis_tdata[14:0])),
        .center_y  ($signed(s_axis_tdata[29:15])),
        .radius    (s_axis_tdata[43:30]),
        .fill_mode (s_axis_tdata[44]),
        .job       (job)
    );

    mcr_emit u_emit
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .job_load    (job_load),
        .job         (job),
        .job_free    (job_free),
        .stat        (stat),
        .m_valid     (m_axis_tvalid),
        .m_ready     (m_axis_tready),
        .x_start     (x_start),
        .x_end       (x_end),
        .row_y       (row_y),
        .last_of_run (last_of_run),
        .circle_done (circle_done),
        .empty_res   (empty_res)
    );

    assign m_axis_tdata = {row_y, x_end, x_start};
    assign m_axis_tuser = {empty_res, circle_done};
    assign m_axis_tlast = last_of_run;

`ifndef SYNTHESIS
    // Completion is only ever flagged on the final result of a step
    a_done_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tlast)
        else $error("circle_done without tlast");

    // An empty result is a lone, finished, all-zero result
    a_empty_form: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser[1] |->
            m_axis_tlast && m_axis_tuser[0] && (m_axis_tdata == 48'd0))
        else $error("malformed empty result");

    // A step transfer always leaves a job in flight
    a_step_job: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready && (s_axis_tuser == OP_STEP) |=> stat.job_busy)
        else $error("step accepted without a job");

    // A result only loads while a job is held
    a_load_busy: assert property (@(posedge clk) disable iff (!rst_n)
        stat.out_load |-> stat.job_busy)
        else $error("output load with no job");
`endif

endmodule

@@ tb/sv/midpoint_circle_rasterizer_tb.sv @@
// Self-checking circle rasterizer testbench: directed and random stream traffic with a predictor.
module midpoint_circle_rasterizer_tb;
    import mcr_pkg::*;

    localparam int QUIET_LIMIT = 3000;
    localparam int TAIL_CYCLES = 30;
    localparam int TOTAL_ITEMS = 180;

    // One drawing command as it goes onto the input stream
    typedef struct packed {
        logic                     op;
        logic signed [CoordW-1:0] cx;
        logic signed [CoordW-1:0] cy;
        logic [RadiusW-1:0]       r;
        logic                     fill;
        logic                     hold;   // sender waits for an empty scoreboard first
    } draw_cmd_t;

    // One expected point or span
    typedef struct packed {
        logic signed [OutW-1:0] xs;
        logic signed [OutW-1:0] xe;
        logic signed [OutW-1:0] y;
        logic                   last;
        logic                   done;
        logic                   empty;
    } span_t;

    typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_SPARSE, RX_PATTERN} rx_mode_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [47:0] s_axis_tdata = '0;
    logic        s_axis_tuser = OP_START;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [47:0] m_axis_tdata;
    logic [1:0]  m_axis_tuser;
    logic        m_axis_tlast;

    draw_cmd_t draw_cmds[$];
    span_t     pending_spans[$];
    draw_cmd_t cur_cmd = '0;
    int        err_count = 0;
    int        quiet_cycles = 0;

    // Sender burst shaping
    int burst_left = 4;
    int gap_left = 0;

    // Receiver stall shaping
    rx_mode_t   rx_mode = RX_OPEN;
    int         rx_mode_left = 40;
    logic [7:0] rx_pattern = 8'hA5;

    // Predicted circle state
    logic signed [CoordW-1:0] c_x = '0;
    logic signed [CoordW-1:0] c_y = '0;
    logic [RadiusW-1:0]       c_rad = '0;
    logic signed [CoordW-1:0] off_x = '0;
    logic signed [CoordW-1:0] off_y = '0;
    logic signed [DecW-1:0]   dec = '0;
    logic                     c_fill = 1'b0;
    logic                     c_active = 1'b0;

    midpoint_circle_rasterizer u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Three-way midpoint update of the offsets and decision term
    function automatic void advance_offsets(input int r, inout int ox, inout int oy,
                                            inout int d);
        if (d >= 2 * ox)
        begin
            d -= 2 * ox + 1;
            ox += 1;
        end
        else if (d < 2 * (r - oy))
        begin
            d += 2 * oy - 1;
            oy -= 1;
        end
        else
        begin
            d += 2 * (oy - ox - 1);
            oy -= 1;
            ox += 1;
        end
    endfunction

    function automatic int steps_to_finish(input int r);
        int ox = 0;
        int oy = r;
        int d = r - 1;
        int n = 0;
        do
        begin
            advance_offsets(r, ox, oy, d);
            n++;
        end
        while (oy >= ox);
        return n;
    endfunction

    function automatic span_t mk_span(input int xs, input int xe, input int row);
        span_t s;
        s = '0;
        s.xs = 16'(xs);
        s.xe = 16'(xe);
        s.y = 16'(row);
        return s;
    endfunction

    // Predict the results of one accepted command and update the circle state
    function automatic void rasterize_item(input draw_cmd_t cmd);
        int    x, y, ox, oy, d, n;
        span_t run[8];
        x = int'(c_x);
        y = int'(c_y);
        ox = int'(off_x);
        oy = int'(off_y);
        d = int'(dec);
        n = 0;
        if (cmd.op == OP_START)
        begin
            c_x = cmd.cx;
            c_y = cmd.cy;
            c_rad = cmd.r;
            c_fill = cmd.fill;
            off_x = '0;
            off_y = 15'(cmd.r);
            dec = 17'(int'(cmd.r) - 1);
            c_active = 1'b1;
        end
        else if (!c_active)
        begin
            run[0] = '0;
            run[0].last = 1'b1;
            run[0].done = 1'b1;
            run[0].empty = 1'b1;
            n = 1;
        end
        else
        begin
            if (c_fill)
            begin
                run[0] = mk_span(x - oy, x + oy, y + ox);
                run[1] = mk_span(x - ox, x + ox, y + oy);
                run[2] = mk_span(x - ox, x + ox, y - oy);
                run[3] = mk_span(x - oy, x + oy, y - ox);
                n = 4;
            end
            else
            begin
                run[0] = mk_span(x + ox, x + ox, y + oy);
                run[1] = mk_span(x + oy, x + oy, y + ox);
                run[2] = mk_span(x - ox, x - ox, y + oy);
                run[3] = mk_span(x - oy, x - oy, y + ox);
                run[4] = mk_span(x + ox, x + ox, y - oy);
                run[5] = mk_span(x + oy, x + oy, y - ox);
                run[6] = mk_span(x - ox, x - ox, y - oy);
                run[7] = mk_span(x - oy, x - oy, y - ox);
                n = 8;
            end
            advance_offsets(int'(c_rad), ox, oy, d);
            off_x = 15'(ox);
            off_y = 15'(oy);
            dec = 17'(d);
            run[n-1].last = 1'b1;
            // circle ends once the offsets cross
            if (off_y < off_x)
            begin
                c_active = 1'b0;
                run[n-1].done = 1'b1;
            end
        end
        for (int i = 0; i < n; i++)
            pending_spans.push_back(run[i]);
    endfunction

    function automatic void push_start(input logic signed [CoordW-1:0] x,
                                       input logic signed [CoordW-1:0] y,
                                       input logic [RadiusW-1:0] r, input logic f,
                                       input logic hold);
        draw_cmd_t c;
        c.op = OP_START;
        c.cx = x;
        c.cy = y;
        c.r = r;
        c.fill = f;
        c.hold = hold;
        draw_cmds.push_back(c);
    endfunction

    // Step commands carry random junk in the fields the block ignores
    function automatic void push_steps(input int n);
        draw_cmd_t c;
        for (int i = 0; i < n; i++)
        begin
            c.op = OP_STEP;
            c.cx = 15'($urandom);
            c.cy = 15'($urandom);
            c.r = 14'($urandom);
            c.fill = 1'($urandom);
            c.hold = 1'b0;
            draw_cmds.push_back(c);
        end
    endfunction

    function automatic void check_field(input string name, input int want, input int got);
        if (want != got)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            err_count++;
        end
    endfunction

    // Driver: feeds queued commands in bursts, predicts on each input transfer
    always @(posedge clk)
    begin : drive
        draw_cmd_t nxt;
        if (s_axis_tvalid && s_axis_tready)
            rasterize_item(cur_cmd);
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
        end
        else if (s_axis_tvalid && !s_axis_tready)
        begin
            // hold the offered transfer
        end
        else if (gap_left != 0)
        begin
            gap_left <= gap_left - 1;
            s_axis_tvalid <= 1'b0;
        end
        else if (draw_cmds.size() != 0 && !(draw_cmds[0].hold && pending_spans.size() != 0))
        begin
            nxt = draw_cmds.pop_front();
            cur_cmd <= nxt;
            s_axis_tdata <= {3'b000, nxt.fill, nxt.r, nxt.cy, nxt.cx};
            s_axis_tuser <= nxt.op;
            s_axis_tvalid <= 1'b1;
            if (burst_left <= 1)
            begin
                burst_left <= $urandom_range(1, 12);
                gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 9);
            end
            else
            begin
                burst_left <= burst_left - 1;
            end
        end
        else
        begin
            s_axis_tvalid <= 1'b0;
        end
    end

    // Monitor: checks each output transfer, then shapes the ready pattern
    always @(posedge clk)
    begin : observe
        span_t want;
        logic  rdy;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (pending_spans.size() == 0)
            begin
                $error("unexpected result: x_start %0d, row_y %0d",
                       $signed(m_axis_tdata[15:0]), $signed(m_axis_tdata[47:32]));
                err_count++;
            end
            else
            begin
                want = pending_spans.pop_front();
                check_field("x_start", want.xs, $signed(m_axis_tdata[15:0]));
                check_field("x_end", want.xe, $signed(m_axis_tdata[31:16]));
                check_field("row_y", want.y, $signed(m_axis_tdata[47:32]));
                check_field("last_of_run", want.last, m_axis_tlast);
                check_field("circle_done", want.done, m_axis_tuser[0]);
                check_field("empty_res", want.empty, m_axis_tuser[1]);
            end
        end
        if (rx_mode_left == 0)
        begin
            rx_mode <= rx_mode_t'($urandom_range(0, 3));
            rx_mode_left <= $urandom_range(20, 80);
            rx_pattern <= 8'($urandom) | 8'h01;
        end
        else
        begin
            rx_mode_left <= rx_mode_left - 1;
            rx_pattern <= {rx_pattern[6:0], rx_pattern[7]};
        end
        case (rx_mode)
            RX_OPEN:   rdy = 1'b1;
            RX_COIN:   rdy = 1'($urandom_range(0, 1));
            RX_SPARSE: rdy = ($urandom_range(0, 3) == 0);
            default:   rdy = rx_pattern[0];
        endcase
        m_axis_tready <= rdy;
    end

    // Watchdog: cycles without any transfer on either side
    always @(posedge clk)
    begin
        if (!rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        wait (quiet_cycles >= QUIET_LIMIT);
        $display("DONE: errors detected");
        $finish;
    end

    initial
    begin : stimulus
        int pick, r;

        // Directed: idle step, zero radius both modes, coordinate extremes
        push_steps(1);
        push_start(15'sd0, 15'sd0, 14'd0, 1'b0, 1'b0);
        push_steps(2);
        push_start(-15'sd16384, 15'sd16383, 14'd0, 1'b1, 1'b0);
        push_steps(1);
        push_start(15'sd16383, -15'sd16384, 14'd1, 1'b0, 1'b0);
        push_steps(2);
        push_start(-15'sd16384, -15'sd16384, 14'd16383, 1'b0, 1'b0);
        push_steps(2);
        push_start(15'sd16383, 15'sd16383, 14'd16383, 1'b1, 1'b1);
        push_steps(2);
        // start abandoned by a second start, then a full circle and one idle step
        push_start(-15'sd1, 15'sd1, 14'd5, 1'b1, 1'b0);
        push_start(15'sd100, -15'sd100, 14'd3, 1'b1, 1'b0);
        push_steps(steps_to_finish(3) + 1);

        // Random: mostly complete small circles, some abandoned or stray steps
        while (draw_cmds.size() < TOTAL_ITEMS)
        begin
            pick = $urandom_range(0, 19);
            if (pick < 14)
            begin
                r = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(0, 12);
                push_start(15'($urandom), 15'($urandom), 14'(r), 1'($urandom),
                           $urandom_range(0, 24) == 0);
                push_steps(steps_to_finish(r) + int'($urandom_range(0, 3) == 0));
            end
            else if (pick < 17)
            begin
                push_start(15'($urandom), 15'($urandom), 14'($urandom), 1'($urandom), 1'b0);
                push_steps($urandom_range(0, 5));
            end
            else
            begin
                push_steps(1);
            end
        end

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        while (draw_cmds.size() != 0 || s_axis_tvalid)
            @(posedge clk);
        while (pending_spans.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        if (err_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
